>>> design/rc_ppm_channel_capture_defines.svh
// assertion macros for the ppm channel capture block
`ifndef RC_PPM_CHANNEL_CAPTURE_DEFINES_SVH
`define RC_PPM_CHANNEL_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS

// concurrent check on clk, skipped while reset is held
`define RCPPM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// concurrent check on clk, also evaluated during reset
`define RCPPM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RCPPM_ASSERT(label, prop, msg)
`define RCPPM_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> design/rcppm_pkg.sv
// shared types and constants of the ppm channel capture block
package rcppm_pkg;

	// result codes
	typedef enum logic [1:0] {
		EV_SYNC    = 2'd0,
		EV_STORED  = 2'd1,
		EV_IGNORED = 2'd2
	} event_kind_t;

	// input mode codes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_EDGE = 1'b1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SYNC_TICKS    = 2'd0,
		REG_PULSE_OFFSET  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} reg_index_t;

	localparam int unsigned CFG_DATA_W = 16;

	// register reset values
	localparam logic [7:0]  SYNC_TICKS_RST    = 8'd46;
	localparam logic [15:0] PULSE_OFFSET_RST  = 16'd4140;
	localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd6;

	// coarse timer saturation point
	localparam logic [8:0] COARSE_MAX = 9'd511;

endpackage

>>> design/rcppm_if.sv
// handshake channels of the ppm channel capture block
interface rcppm_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] fine_count;

	modport source (output valid, output mode, output fine_count, input ready);
	modport sink   (input valid, input mode, input fine_count, output ready);
endinterface

interface rcppm_out_if;
	logic                     valid;
	logic                     ready;
	rcppm_pkg::event_kind_t   event_kind;
	logic [2:0]               channel;
	logic [15:0]              pulse_value;

	modport source (output valid, output event_kind, output channel, output pulse_value,
		input ready);
	modport sink   (input valid, input event_kind, input channel, input pulse_value,
		output ready);
endinterface

>>> design/rc_ppm_channel_capture.sv
// ppm pulse train decoder: coarse timer, channel index and averaged channel store
// an accepted edge beat loads its result into the output register
// throughput: one beat per cycle, ticks and edges alike; ticks give no result
// the input stalls only while a result sits in the output register untaken
// reset: arst_n clears timer, index, channel store, output valid and restores
// the configuration registers to their defaults
`include "rc_ppm_channel_capture_defines.svh"

module rc_ppm_channel_capture #(
	parameter int unsigned MAX_CHANNELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [rcppm_pkg::CFG_DATA_W-1:0] wr_data,
	rcppm_in_if.sink           capture,
	rcppm_out_if.source        report
);

	// index counter holds 0..MAX_CHANNELS, store address needs one less value
	localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	// compare width covers both the 4-bit register and the counter
	localparam int unsigned LIM_W = (CNT_W > 4) ? CNT_W : 4;

	// configuration registers
	logic [7:0]  sync_ticks_q;
	logic [15:0] pulse_offset_q;
	logic [3:0]  channel_count_q;

	// decoder state
	logic [8:0]       coarse_q;
	logic [CNT_W-1:0] chan_idx_q;
	logic [15:0]      store_q [MAX_CHANNELS];

	// output register
	logic                   out_valid_q;
	rcppm_pkg::event_kind_t out_kind_q;
	logic [2:0]             out_chan_q;
	logic [15:0]            out_pulse_q;

	// handshake
	logic take_in;
	logic take_tick;
	logic take_edge;

	// edge decode
	logic [LIM_W-1:0] limit;
	logic [LIM_W-1:0] cnt_ext;
	logic [LIM_W-1:0] max_ext;
	logic [LIM_W-1:0] idx_ext;
	logic             is_sync;
	logic             can_store;
	logic [IDX_W-1:0] store_addr;
	logic [15:0]      elapsed;
	logic [15:0]      net_pulse;
	logic [16:0]      pulse_sum;
	logic [15:0]      avg;

	// ---------------------------------------------------------------
	// configuration port, writes beyond the register list are dropped
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_ticks_q    <= rcppm_pkg::SYNC_TICKS_RST;
			pulse_offset_q  <= rcppm_pkg::PULSE_OFFSET_RST;
			channel_count_q <= rcppm_pkg::CHANNEL_COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				rcppm_pkg::REG_SYNC_TICKS:    sync_ticks_q    <= wr_data[7:0];
				rcppm_pkg::REG_PULSE_OFFSET:  pulse_offset_q  <= wr_data[15:0];
				rcppm_pkg::REG_CHANNEL_COUNT: channel_count_q <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// input handshake: free whenever the output register is empty or draining
	// ---------------------------------------------------------------
	assign capture.ready = !out_valid_q || report.ready;
	assign take_in       = capture.valid && capture.ready;
	assign take_tick     = take_in && (capture.mode == rcppm_pkg::MODE_TICK);
	assign take_edge     = take_in && (capture.mode == rcppm_pkg::MODE_EDGE);

	// ---------------------------------------------------------------
	// edge decode, all in one pass from the state registers
	// ---------------------------------------------------------------
	always_comb begin
		// channel count above the store depth acts as the store depth
		cnt_ext = LIM_W'(channel_count_q);
		max_ext = LIM_W'(MAX_CHANNELS);
		limit   = (cnt_ext > max_ext) ? max_ext : cnt_ext;
		idx_ext = LIM_W'(chan_idx_q);

		// a gap beyond the sync threshold restarts the frame
		is_sync   = coarse_q > {1'b0, sync_ticks_q};
		can_store = idx_ext < limit;

		store_addr = chan_idx_q[IDX_W-1:0];

		// not a sync, so the coarse count fits 8 bits here
		elapsed   = {coarse_q[7:0], capture.fine_count};
		net_pulse = (elapsed < pulse_offset_q) ? 16'd0 : (elapsed - pulse_offset_q);
		pulse_sum = {1'b0, net_pulse} + {1'b0, store_q[store_addr]};
		avg       = pulse_sum[16:1];
	end

	// ---------------------------------------------------------------
	// coarse timer: ticks count up and hold at the top, edges clear it
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coarse_q <= '0;
		end else if (take_edge) begin
			coarse_q <= '0;
		end else if (take_tick && (coarse_q != rcppm_pkg::COARSE_MAX)) begin
			coarse_q <= coarse_q + 9'd1;
		end
	end

	// ---------------------------------------------------------------
	// channel index and store, index parks at the channel count (capped at the store depth) until sync
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_idx_q <= '0;
			for (int k = 0; k < MAX_CHANNELS; k++) begin
				store_q[k] <= '0;
			end
		end else if (take_edge) begin
			if (is_sync) begin
				chan_idx_q <= '0;
			end else if (can_store) begin
				chan_idx_q          <= chan_idx_q + CNT_W'(1);
				store_q[store_addr] <= avg;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register, loaded by every edge beat
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_edge) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (take_edge) begin
			if (is_sync) begin
				out_kind_q  <= rcppm_pkg::EV_SYNC;
				out_chan_q  <= 3'd0;
				out_pulse_q <= 16'd0;
			end else if (can_store) begin
				out_kind_q  <= rcppm_pkg::EV_STORED;
				out_chan_q  <= 3'(chan_idx_q);
				out_pulse_q <= avg;
			end else begin
				out_kind_q  <= rcppm_pkg::EV_IGNORED;
				out_chan_q  <= 3'd0;
				out_pulse_q <= 16'd0;
			end
		end
	end

	assign report.valid       = out_valid_q;
	assign report.event_kind  = out_kind_q;
	assign report.channel     = out_chan_q;
	assign report.pulse_value = out_pulse_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`RCPPM_ASSERT_ALWAYS(a_idx_range, (CNT_W'(MAX_CHANNELS) >= chan_idx_q), "channel index past store depth")
	`RCPPM_ASSERT(a_coarse_hold, (take_tick && (coarse_q == rcppm_pkg::COARSE_MAX)) |=> (coarse_q == rcppm_pkg::COARSE_MAX), "coarse timer left saturation on a tick")
	`RCPPM_ASSERT(a_edge_result, take_edge |=> (out_valid_q && (coarse_q == 9'd0)), "edge beat without result or timer clear")
	`RCPPM_ASSERT(a_stored_idx, (out_valid_q && (out_kind_q == rcppm_pkg::EV_STORED)) |-> (chan_idx_q != '0), "stored result with index at zero")
	`RCPPM_ASSERT(a_zero_payload, (out_valid_q && (out_kind_q != rcppm_pkg::EV_STORED)) |-> ((out_chan_q == 3'd0) && (out_pulse_q == 16'd0)), "nonzero payload on sync or ignored result")

endmodule

>>> tb/rc_ppm_channel_capture_test.sv
// testbench of the ppm channel capture block: directed and random pulse trains checked against a predictor
`timescale 1ns / 1ps

module rc_ppm_channel_capture_test;

	localparam int unsigned MAX_CH       = 8;
	localparam int unsigned RANDOM_BEATS = 400;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	// index 3 has no register behind it
	localparam logic [1:0]  REG_UNUSED   = 2'd3;

	// one result beat as the block gives it out
	typedef struct packed {
		rcppm_pkg::event_kind_t kind;
		logic [2:0]  chan;
		logic [15:0] width;
	} pulse_event_t;

	// predictor of the decoder plus the queue of results it still awaits
	class ppm_scoreboard;
		pulse_event_t awaited[$];
		logic [7:0]   sync_thr;
		logic [15:0]  offset;
		logic [3:0]   count;
		logic [8:0]   coarse;
		logic [3:0]   idx;
		logic [15:0]  widths[MAX_CH];
		int unsigned  errors;

		function new();
			sync_thr = rcppm_pkg::SYNC_TICKS_RST;
			offset   = rcppm_pkg::PULSE_OFFSET_RST;
			count    = rcppm_pkg::CHANNEL_COUNT_RST;
			coarse   = '0;
			idx      = '0;
			errors   = 0;
			foreach (widths[k])
				widths[k] = '0;
		endfunction

		function void set_reg(logic [1:0] ridx, logic [15:0] data);
			case (ridx)
				rcppm_pkg::REG_SYNC_TICKS:    sync_thr = data[7:0];
				rcppm_pkg::REG_PULSE_OFFSET:  offset = data;
				rcppm_pkg::REG_CHANNEL_COUNT: count = data[3:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_beat(logic mode, logic [7:0] fine);
			pulse_event_t ev;
			logic [3:0]   lim;
			logic [15:0]  span, cut;
			logic [16:0]  total;
			if (mode == rcppm_pkg::MODE_TICK) begin
				if (coarse != rcppm_pkg::COARSE_MAX)
					coarse = coarse + 9'd1;
				return;
			end
			lim = (count > MAX_CH) ? 4'(MAX_CH) : count;
			ev.kind  = rcppm_pkg::EV_IGNORED;
			ev.chan  = '0;
			ev.width = '0;
			if (coarse > {1'b0, sync_thr}) begin
				idx = '0;
				ev.kind = rcppm_pkg::EV_SYNC;
			end else if (idx < lim) begin
				// coarse is at most 255 here, so the gap fits 16 bits
				span  = {coarse[7:0], fine};
				cut   = (span < offset) ? span : offset;
				total = {1'b0, span - cut} + {1'b0, widths[idx[2:0]]};
				widths[idx[2:0]] = total[16:1];
				ev.kind  = rcppm_pkg::EV_STORED;
				ev.chan  = idx[2:0];
				ev.width = total[16:1];
				idx = idx + 4'd1;
			end
			awaited.push_back(ev);
			coarse = '0;
		endfunction

		task log_mismatch(string msg);
			errors++;
			$display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_event(rcppm_pkg::event_kind_t kind, logic [2:0] chan, logic [15:0] width);
			pulse_event_t head;
			if (awaited.size() == 0) begin
				log_mismatch($sformatf("result beat kind %0d with nothing awaited", kind));
				return;
			end
			head = awaited.pop_front();
			if (kind !== head.kind)
				log_mismatch($sformatf("event kind %0d, wanted %0d", kind, head.kind));
			if (chan !== head.chan)
				log_mismatch($sformatf("channel %0d, wanted %0d", chan, head.chan));
			if (width !== head.width)
				log_mismatch($sformatf("pulse value %0d, wanted %0d", width, head.width));
		endtask

		task leftover_check();
			if (awaited.size() != 0)
				log_mismatch($sformatf("%0d results never came", awaited.size()));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [15:0] wr_data;

	rcppm_in_if  capture ();
	rcppm_out_if report ();

	rc_ppm_channel_capture #(
		.MAX_CHANNELS(MAX_CH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.capture (capture),
		.report  (report)
	);

	ppm_scoreboard scoreboard = new();

	// shared between the driving processes
	int unsigned sent_beats   = 0;
	int unsigned cycle_count  = 0;
	bit          gaps_on      = 1'b1;
	bit          quiet        = 1'b0;
	bit          hold_req     = 1'b0;

	// current register values as the stimulus knows them, used to shape frames
	logic [7:0]  cfg_sync  = rcppm_pkg::SYNC_TICKS_RST;
	logic [3:0]  cfg_count = rcppm_pkg::CHANNEL_COUNT_RST;

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// beat monitor: values seen here are the ones before this edge's updates
	always @(posedge clk) begin
		if (arst_n) begin
			// a result at this edge always belongs to an earlier edge beat
			if (report.valid && report.ready)
				scoreboard.check_event(report.event_kind, report.channel, report.pulse_value);
			if (capture.valid && capture.ready)
				scoreboard.note_beat(capture.mode, capture.fine_count);
		end
	end

	// result side: random stall bursts, one long hold-off, none at the end
	initial begin : sink_side
		report.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				// long hold so the output register fills and the input stalls
				hold_req = 1'b0;
				report.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(7) == 0 && (cycle_count % 400) < 250) begin
				report.ready <= 1'b0;
				repeat ($urandom_range(13, 1)) @(posedge clk);
			end else begin
				report.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// one input beat, with an occasional idle burst in front of it
	task automatic send_beat(input logic mode, input logic [7:0] fine);
		if (!quiet && gaps_on && $urandom_range(7) == 0) begin
			capture.valid <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
		capture.valid      <= 1'b1;
		capture.mode       <= mode;
		capture.fine_count <= fine;
		do @(posedge clk); while (!capture.ready);
		sent_beats++;
		// toggle between stretches with and without idling
		if ($urandom_range(99) == 0)
			gaps_on = !gaps_on;
	endtask

	// fine count is random on ticks, the block must ignore it
	task automatic tick_run(input int unsigned n);
		repeat (n) send_beat(rcppm_pkg::MODE_TICK, 8'($urandom));
	endtask

	task automatic pulse(input int unsigned ticks, input logic [7:0] fine);
		tick_run(ticks);
		send_beat(rcppm_pkg::MODE_EDGE, fine);
	endtask

	// register write once every awaited result is out and the block is quiet
	task automatic program_reg(input logic [1:0] ridx, input logic [15:0] data);
		capture.valid <= 1'b0;
		do @(posedge clk); while (scoreboard.pending() != 0);
		repeat (2) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= ridx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		scoreboard.set_reg(ridx, data);
		if (ridx == rcppm_pkg::REG_SYNC_TICKS)
			cfg_sync = data[7:0];
		else if (ridx == rcppm_pkg::REG_CHANNEL_COUNT)
			cfg_count = data[3:0];
	endtask

	// new register set for a random phase; unused upper data bits are random
	task automatic random_setup();
		logic [7:0]  s;
		logic [15:0] o;
		logic [3:0]  c;
		case ($urandom_range(9))
			0:       s = 8'd0;
			1:       s = 8'd255;
			2, 3, 4, 5: s = 8'($urandom_range(6, 1));
			6, 7:    s = 8'($urandom_range(30, 7));
			8:       s = rcppm_pkg::SYNC_TICKS_RST;
			default: s = 8'($urandom_range(254, 31));
		endcase
		case ($urandom_range(5))
			0:       o = 16'd0;
			1:       o = 16'hFFFF;
			2, 3:    o = 16'($urandom_range(8000));
			default: o = 16'($urandom);
		endcase
		if ($urandom_range(3) == 0)
			c = 4'($urandom_range(15));
		else
			c = 4'($urandom_range(MAX_CH, 1));
		if ($urandom_range(4) != 0)
			program_reg(rcppm_pkg::REG_SYNC_TICKS, {8'($urandom), s});
		if ($urandom_range(4) != 0)
			program_reg(rcppm_pkg::REG_PULSE_OFFSET, o);
		if ($urandom_range(4) != 0)
			program_reg(rcppm_pkg::REG_CHANNEL_COUNT, {12'($urandom), c});
	endtask

	// sync gap followed by a run of channel pulses, sometimes fewer, or one or two more, than the channel limit
	task automatic random_frame();
		int unsigned lim, n, pcap;
		lim  = (cfg_count > MAX_CH) ? MAX_CH : cfg_count;
		pcap = (cfg_sync < 30 || $urandom_range(3) == 0) ? cfg_sync : 30;
		tick_run(cfg_sync + 1 + $urandom_range(2));
		case ($urandom_range(5))
			0:       n = $urandom_range(lim);
			1:       n = lim + 1 + $urandom_range(1);
			default: n = lim;
		endcase
		repeat (n) pulse($urandom_range(pcap), 8'($urandom));
	endtask

	// unframed mix of ticks and edges, now and then a very long gap
	task automatic random_noise();
		if ($urandom_range(9) == 0)
			tick_run($urandom_range(600, 100));
		repeat ($urandom_range(20, 4)) begin
			if ($urandom_range(2) == 0)
				send_beat(rcppm_pkg::MODE_EDGE, 8'($urandom));
			else
				send_beat(rcppm_pkg::MODE_TICK, 8'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned random_start;
		capture.valid      <= 1'b0;
		capture.mode       <= rcppm_pkg::MODE_TICK;
		capture.fine_count <= '0;
		wr_en              <= 1'b0;
		wr_index           <= rcppm_pkg::REG_SYNC_TICKS;
		wr_data            <= '0;
		arst_n             <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: sync above 46 ticks, offset 4140, six channels
		send_beat(rcppm_pkg::MODE_EDGE, 8'h00);  // edge straight after reset, zero gap
		pulse(47, 8'h00);                   // one above the threshold
		pulse(46, 8'hFF);                   // gap at the threshold is a pulse
		pulse(16, 8'd44);                   // gap equals the offset exactly
		pulse(16, 8'd43);                   // one below the offset floors to zero
		pulse(20, 8'h80);
		pulse(24, 8'h55);
		pulse(31, 8'hAA);
		pulse(5, 8'h0F);                    // past the last channel

		// widest pulse, no offset, all channels; upper data bits must be dropped
		program_reg(rcppm_pkg::REG_SYNC_TICKS, 16'hABFF);
		program_reg(rcppm_pkg::REG_PULSE_OFFSET, 16'h0000);
		program_reg(rcppm_pkg::REG_CHANNEL_COUNT, 16'h0008);
		pulse(520, 8'hFF);                  // timer saturates, still a sync
		pulse(255, 8'hFF);                  // average carries past 16 bits

		// count above the channel limit, offset eats every pulse, dead index
		program_reg(rcppm_pkg::REG_PULSE_OFFSET, 16'hFFFF);
		program_reg(rcppm_pkg::REG_CHANNEL_COUNT, 16'hFFFF);
		program_reg(rcppm_pkg::REG_SYNC_TICKS, 16'h0003);
		program_reg(REG_UNUSED, 16'h0000);
		pulse(4, 8'h00);
		repeat (MAX_CH + 1) pulse(1, 8'($urandom));

		// zero channels stores nothing
		program_reg(rcppm_pkg::REG_CHANNEL_COUNT, 16'h0000);
		pulse(4, 8'h00);
		pulse(0, 8'hFF);

		// long hold-off on the result side while beats keep coming
		capture.valid <= 1'b0;
		hold_req = 1'b1;
		wait (!hold_req);
		repeat (8) pulse(1, 8'($urandom));

		random_start = sent_beats;
		while (sent_beats - random_start < RANDOM_BEATS) begin
			random_setup();
			repeat ($urandom_range(6, 2)) begin
				if (sent_beats - random_start >= RANDOM_BEATS)
					break;
				if ($urandom_range(6) == 0)
					random_noise();
				else
					random_frame();
				if (sent_beats - random_start + 150 >= RANDOM_BEATS)
					quiet = 1'b1;
			end
		end

		// drain, then let anything still inside the block come out
		capture.valid <= 1'b0;
		do @(posedge clk); while (scoreboard.pending() != 0);
		repeat (4) @(posedge clk);
		scoreboard.leftover_check();
		if (scoreboard.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
